FILE: rtl/rwmt_pkg.sv
package rwmt_pkg;

  localparam int unsigned SCAN_LIMIT = 65536;
  localparam int unsigned SCAN_W = $clog2(SCAN_LIMIT + 1);

  localparam logic [31:0] ID_RIFF = 32'h52494646;
  localparam logic [31:0] ID_WAVE = 32'h57415645;
  localparam logic [31:0] ID_LIST = 32'h4C495354;
  localparam logic [31:0] ID_INFO = 32'h494E464F;
  localparam logic [31:0] ID_BEXT = 32'h62657874;
  localparam logic [8:0]  BEXT_MIN = 9'd412;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_CHDR = 2'd1,
    PH_BODY = 2'd2,
    PH_FAIL = 2'd3
  } top_phase_t;

  typedef enum logic [1:0] {
    SP_TYPE = 2'd0,
    SP_HDR  = 2'd1,
    SP_BODY = 2'd2,
    SP_IDLE = 2'd3
  } sub_phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTWAVE = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;
  localparam logic [1:0] ST_OVERRUN = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] field_tag;
    logic       field_first;
    logic [1:0] parse_status;
    logic       last_byte;
  } result_t;

  // INFO subchunk ID to tag code; zero when the ID is not a known field.
  function automatic logic [3:0] info_tag(input logic [31:0] id);
    case (id)
      32'h494E414D: info_tag = 4'd1;
      32'h49415254: info_tag = 4'd2;
      32'h49505244: info_tag = 4'd3;
      32'h49474E52: info_tag = 4'd4;
      32'h49434D54: info_tag = 4'd5;
      32'h49435244: info_tag = 4'd6;
      32'h4954524B: info_tag = 4'd7;
      default:      info_tag = 4'd0;
    endcase
  endfunction

  // Field index in a bext chunk, whether a byte starts a field, and if it is text.
  function automatic logic [2:0] bext_field(input logic [8:0] p);
    if (p < 9'd256)      bext_field = 3'd0;
    else if (p < 9'd288) bext_field = 3'd1;
    else if (p < 9'd320) bext_field = 3'd2;
    else if (p < 9'd330) bext_field = 3'd3;
    else if (p < 9'd338) bext_field = 3'd4;
    else if (p < 9'd346) bext_field = 3'd5;
    else if (p < 9'd348) bext_field = 3'd6;
    else                 bext_field = 3'd7;
  endfunction

  function automatic logic bext_is_start(input logic [8:0] p);
    bext_is_start = (p == 9'd0) || (p == 9'd256) || (p == 9'd288) || (p == 9'd320) ||
                    (p == 9'd330) || (p == 9'd338) || (p == 9'd346) || (p == 9'd348);
  endfunction

  function automatic logic bext_is_text(input logic [2:0] f);
    bext_is_text = !(f == 3'd5 || f == 3'd6);
  endfunction

endpackage

FILE: rtl/rwmt_parser.sv
module rwmt_parser
  import rwmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output result_t    res
);

  top_phase_t  top_phase_r, top_phase_nxt;
  sub_phase_t  sub_phase_r, sub_phase_nxt;
  logic [3:0]  header_count_r, header_count_nxt;
  logic [31:0] chunk_id_r, chunk_id_nxt;
  logic [31:0] chunk_rem_r, chunk_rem_nxt;
  logic        chunk_pad_r, chunk_pad_nxt;
  logic [31:0] list_rem_r, list_rem_nxt;
  logic [2:0]  sub_hcount_r, sub_hcount_nxt;
  logic [31:0] sub_id_r, sub_id_nxt;
  logic [31:0] sub_rem_r, sub_rem_nxt;
  logic        sub_pad_r, sub_pad_nxt;
  logic [8:0]  bext_pos_r, bext_pos_nxt;
  logic        bext_zero_r, bext_zero_nxt;
  logic [1:0]  error_r, error_nxt;
  logic [SCAN_W-1:0] scan_r, scan_nxt;

  logic [3:0]  tag;
  logic        first;
  logic [31:0] new_id, new_rem, sub_new_id, sub_new_rem, list_after;
  logic [3:0]  hc_inc;
  logic [2:0]  sub_hc_inc;
  logic [2:0]  bf;
  logic        bstart;
  logic [1:0]  status;

  always_comb begin
    top_phase_nxt = top_phase_r;  sub_phase_nxt = sub_phase_r;
    header_count_nxt = header_count_r;  chunk_id_nxt = chunk_id_r;
    chunk_rem_nxt = chunk_rem_r;  chunk_pad_nxt = chunk_pad_r;
    list_rem_nxt = list_rem_r;  sub_hcount_nxt = sub_hcount_r;
    sub_id_nxt = sub_id_r;  sub_rem_nxt = sub_rem_r;  sub_pad_nxt = sub_pad_r;
    bext_pos_nxt = bext_pos_r;  bext_zero_nxt = bext_zero_r;
    error_nxt = error_r;  scan_nxt = scan_r;
    tag = 4'd0;  first = 1'b0;
    new_id = {chunk_id_r[23:0], data_byte};
    new_rem = {data_byte, chunk_rem_r[31:8]};
    sub_new_id = {sub_id_r[23:0], data_byte};
    sub_new_rem = {data_byte, sub_rem_r[31:8]};
    hc_inc = header_count_r + 4'd1;
    sub_hc_inc = sub_hcount_r + 3'd1;
    list_after = (list_rem_r != 32'd0) ? list_rem_r - 32'd1 : 32'd0;
    bf = bext_field(bext_pos_r);
    bstart = bext_is_start(bext_pos_r);

    if (scan_r < SCAN_W'(SCAN_LIMIT)) begin
      scan_nxt = scan_r + SCAN_W'(1);
      case (top_phase_r)
        PH_HDR: begin
          chunk_id_nxt = new_id;
          header_count_nxt = hc_inc;
          if (hc_inc == 4'd4 && new_id != ID_RIFF) begin
            top_phase_nxt = PH_FAIL;  error_nxt = ST_NOTWAVE;
          end else if (hc_inc >= 4'd12) begin
            header_count_nxt = 4'd0;
            if (new_id != ID_WAVE) begin
              top_phase_nxt = PH_FAIL;  error_nxt = ST_NOTWAVE;
            end else begin
              top_phase_nxt = PH_CHDR;
            end
          end
        end
        PH_CHDR: begin
          if (chunk_pad_r) begin
            chunk_pad_nxt = 1'b0;
          end else begin
            if (header_count_r < 4'd4) chunk_id_nxt = new_id;
            else chunk_rem_nxt = new_rem;
            header_count_nxt = hc_inc;
            if (hc_inc >= 4'd8) begin
              header_count_nxt = 4'd0;
              list_rem_nxt = chunk_rem_nxt;
              bext_pos_nxt = (chunk_rem_nxt >= 32'(BEXT_MIN)) ? 9'd0 : BEXT_MIN;
              bext_zero_nxt = 1'b0;
              sub_phase_nxt = SP_TYPE;  sub_hcount_nxt = 3'd0;  sub_id_nxt = 32'd0;
              sub_rem_nxt = 32'd0;  sub_pad_nxt = 1'b0;
              chunk_pad_nxt = chunk_rem_nxt[0];
              if (chunk_rem_nxt != 32'd0) top_phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (chunk_id_r == ID_LIST) begin
            list_rem_nxt = list_after;
            case (sub_phase_r)
              SP_TYPE: begin
                sub_id_nxt = sub_new_id;
                sub_hcount_nxt = sub_hc_inc;
                if (sub_hc_inc >= 3'd4) begin
                  sub_hcount_nxt = 3'd0;
                  sub_phase_nxt = (sub_new_id == ID_INFO) ? SP_HDR : SP_IDLE;
                end
              end
              SP_HDR: begin
                if (sub_pad_r) begin
                  sub_pad_nxt = 1'b0;
                end else if (sub_hcount_r == 3'd0 && list_rem_r < 32'd8) begin
                  sub_phase_nxt = SP_IDLE;
                end else begin
                  if (sub_hcount_r < 3'd4) sub_id_nxt = sub_new_id;
                  else sub_rem_nxt = sub_new_rem;
                  sub_hcount_nxt = sub_hc_inc;
                  if (sub_hcount_r == 3'd7) begin
                    sub_hcount_nxt = 3'd0;
                    if (sub_new_rem > list_after) begin
                      if (error_r == ST_OK) error_nxt = ST_OVERRUN;
                      sub_phase_nxt = SP_IDLE;
                    end else if (sub_new_rem != 32'd0) begin
                      sub_pad_nxt = sub_new_rem[0];
                      sub_phase_nxt = SP_BODY;
                    end
                  end
                end
              end
              SP_BODY: begin
                tag = info_tag(sub_id_r);
                first = (tag != 4'd0) && (sub_hcount_r == 3'd0);
                sub_hcount_nxt = 3'd1;
                sub_rem_nxt = sub_rem_r - 32'd1;
                if (sub_rem_r == 32'd1) begin
                  sub_hcount_nxt = 3'd0;
                  sub_phase_nxt = SP_HDR;
                end
              end
              default: ;
            endcase
          end else if (chunk_id_r == ID_BEXT && bext_pos_r < BEXT_MIN) begin
            bext_zero_nxt = bstart ? 1'b0 : bext_zero_r;
            if (bext_is_text(bf) && (bext_zero_nxt || data_byte == 8'd0)) begin
              bext_zero_nxt = 1'b1;
            end else begin
              tag = {1'b1, bf};
              first = bstart;
            end
            bext_pos_nxt = bext_pos_r + 9'd1;
          end
          chunk_rem_nxt = chunk_rem_r - 32'd1;
          if (chunk_rem_r == 32'd1) top_phase_nxt = PH_CHDR;
        end
        default: ;
      endcase
    end

    status = error_nxt;
    if (last_byte && error_nxt != ST_NOTWAVE &&
        !(top_phase_nxt == PH_CHDR && header_count_nxt == 4'd0))
      status = ST_TRUNC;

    res.data_byte = data_byte;
    res.field_tag = tag;
    res.field_first = first;
    res.parse_status = status;
    res.last_byte = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      top_phase_r <= PH_HDR;  sub_phase_r <= SP_TYPE;
      header_count_r <= 4'd0;  chunk_id_r <= 32'd0;  chunk_rem_r <= 32'd0;
      chunk_pad_r <= 1'b0;  list_rem_r <= 32'd0;  sub_hcount_r <= 3'd0;
      sub_id_r <= 32'd0;  sub_rem_r <= 32'd0;  sub_pad_r <= 1'b0;
      bext_pos_r <= 9'd0;  bext_zero_r <= 1'b0;  error_r <= ST_OK;
      scan_r <= '0;
    end else if (step) begin
      top_phase_r <= top_phase_nxt;  sub_phase_r <= sub_phase_nxt;
      header_count_r <= header_count_nxt;  chunk_id_r <= chunk_id_nxt;
      chunk_rem_r <= chunk_rem_nxt;  chunk_pad_r <= chunk_pad_nxt;
      list_rem_r <= list_rem_nxt;  sub_hcount_r <= sub_hcount_nxt;
      sub_id_r <= sub_id_nxt;  sub_rem_r <= sub_rem_nxt;  sub_pad_r <= sub_pad_nxt;
      bext_pos_r <= bext_pos_nxt;  bext_zero_r <= bext_zero_nxt;
      error_r <= error_nxt;  scan_r <= scan_nxt;
    end
  end

endmodule

FILE: rtl/rwmt_out_reg.sv
module rwmt_out_reg
  import rwmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    take,
  output logic    valid,
  output result_t res_out
);

  logic    valid_r;
  result_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (load) valid_r <= 1'b1;
    else if (take) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

  assign valid = valid_r;
  assign res_out = res_r;

endmodule

FILE: rtl/riff_wav_metadata_tagger_top.sv
// RIFF/WAVE metadata tagger.
// The slave channel takes one byte of a WAV file per beat (in_tdata) with
// in_tlast on the final byte of the stream. For every input beat the master
// channel returns exactly one beat: the same byte and the running parse status
// on out_tdata, a field tag that names the INFO or bext metadata field the byte
// belongs to and a first-byte flag on out_tuser, with out_tlast copied from
// the input.
// The parser state advances in the same cycle a byte is accepted, and the
// result sits in a single output register from the cycle after acceptance;
// one byte per cycle is sustained while out_tready is high. in_tready is high
// while the output register is empty or is being emptied in the same cycle;
// a stall on out_tready holds the result and stops intake after that one beat.
// Synchronous reset (rst_n low) returns the parser to the file-header phase
// and empties the output register. The beat carrying in_tlast also returns
// the parser to that phase, so the next byte starts a new stream.
// Only the first SCAN_LIMIT bytes of a stream are parsed; later bytes pass
// through untagged.
module riff_wav_metadata_tagger_top
  import rwmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_byte[7:0], parse_status[9:8], zero
  output logic [4:0]  out_tuser,  // field_tag[3:0], field_first[4]
  output logic        out_tlast   // out_last
);

  result_t res, res_q;
  logic    accept;

  assign in_tready = !out_tvalid || out_tready;
  assign accept = in_tvalid && in_tready;

  rwmt_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res       (res)
  );

  rwmt_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .res_in  (res),
    .take    (out_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tdata = {6'd0, res_q.parse_status, res_q.data_byte};
  assign out_tuser = {res_q.field_first, res_q.field_tag};
  assign out_tlast = res_q.last_byte;

endmodule

FILE: rtl/rwmt_checker.sv
module rwmt_checker
  import rwmt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  // Untagged bytes never carry the first-byte flag.
  a_first_tagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:0] == 4'd0 |-> !out_tuser[4])
    else $error("field_first without tag");

  // Every accepted byte shows up as a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("result missing after accept");

  // Intake is open whenever the output side is draining.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("in_tready low while output drains");

  // A waiting result holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind riff_wav_metadata_tagger_top rwmt_checker u_rwmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
